// ----- sv/ors_pkg.sv -----
// ----------------------------------------------------------------------------
// ors_pkg
// Shared types, codes and the CRC8 step for the ROM search decision core.
// ----------------------------------------------------------------------------
package ors_pkg;

    // function codes of an input beat
    localparam logic [2:0] FUNC_START_FIRST = 3'd0;
    localparam logic [2:0] FUNC_START_NEXT  = 3'd1;
    localparam logic [2:0] FUNC_BIT_PAIR    = 3'd2;
    localparam logic [2:0] FUNC_TARGET      = 3'd3;
    localparam logic [2:0] FUNC_FAMILY_SKIP = 3'd4;

    // status codes of a result beat
    localparam logic [2:0] STATUS_ACK      = 3'd0;
    localparam logic [2:0] STATUS_BEGUN    = 3'd1;
    localparam logic [2:0] STATUS_CONTINUE = 3'd2;
    localparam logic [2:0] STATUS_FOUND    = 3'd3;
    localparam logic [2:0] STATUS_FAIL     = 3'd4;

    // search geometry
    localparam logic [6:0] ROM_BITS_TOTAL = 7'd64;
    localparam logic [6:0] BIT_END        = 7'd65;
    localparam logic [6:0] FAMILY_LIMIT   = 7'd9;

    // reflected polynomial of x^8+x^5+x^4+1
    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef struct packed {
        logic [2:0] func;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
        logic [7:0] target_family;
    } ors_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        write_valid;
        logic        direction;
        logic [63:0] rom_code;
        logic        last_device;
    } ors_result_t;

    // table entry of the byte-wise crc8, lsb first
    function automatic logic [7:0] crc8_lookup(input logic [7:0] idx);
        logic [7:0] crc;
        crc = idx;
        for (int i = 0; i < 8; i++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- sv/ors_in_stage.sv -----
// ----------------------------------------------------------------------------
// ors_in_stage
// Input register of the search core; holds one beat until the core takes it.
// ----------------------------------------------------------------------------
module ors_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ors_pkg::ors_item_t in_item,
    input  logic              advance,
    output logic              stage_valid,
    output ors_pkg::ors_item_t stage_item
);
    import ors_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    ors_item_t item_reg;

    // stall only while a held beat cannot move on
    assign in_stall    = vld_reg && !advance;
    assign stage_valid = vld_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (!in_stall)
        begin
            vld_next = in_valid;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- sv/ors_core.sv -----
// ----------------------------------------------------------------------------
// ors_core
// Search state and the combinational decision step for one beat.
// ----------------------------------------------------------------------------
module ors_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  ors_pkg::ors_item_t   item,
    output ors_pkg::ors_result_t result
);
    import ors_pkg::*;

    logic [63:0] rom_bits_reg;
    logic [63:0] rom_bits_next;
    logic [6:0]  last_disc_reg;
    logic [6:0]  last_disc_next;
    logic [6:0]  family_disc_reg;
    logic [6:0]  family_disc_next;
    logic        last_dev_reg;
    logic        last_dev_next;
    logic [6:0]  bit_pos_reg;
    logic [6:0]  bit_pos_next;
    logic [6:0]  last_zero_reg;
    logic [6:0]  last_zero_next;
    logic [7:0]  crc_reg;
    logic [7:0]  crc_next;
    logic        active_reg;
    logic        active_next;

    logic [5:0]  idx;
    logic [6:0]  bit_pos_inc;
    logic        dir;
    logic [7:0]  crc_byte;
    logic        ok;

    assign idx         = bit_pos_reg[5:0] - 6'd1;
    assign bit_pos_inc = bit_pos_reg + 7'd1;

    // decision step
    always_comb
    begin
        rom_bits_next    = rom_bits_reg;
        last_disc_next   = last_disc_reg;
        family_disc_next = family_disc_reg;
        last_dev_next    = last_dev_reg;
        bit_pos_next     = bit_pos_reg;
        last_zero_next   = last_zero_reg;
        crc_next         = crc_reg;
        active_next      = active_reg;
        dir              = 1'b0;
        crc_byte         = 8'd0;
        ok               = 1'b0;
        result           = '0;
        result.status    = STATUS_ACK;

        unique case (item.func) inside
            FUNC_START_FIRST, FUNC_START_NEXT:
            begin
                if (item.func == FUNC_START_FIRST)
                begin
                    last_disc_next   = 7'd0;
                    family_disc_next = 7'd0;
                    last_dev_next    = 1'b0;
                end
                bit_pos_next   = 7'd1;
                last_zero_next = 7'd0;
                crc_next       = 8'd0;
                active_next    = 1'b0;
                if (last_dev_next || !item.presence)
                begin
                    last_disc_next   = 7'd0;
                    family_disc_next = 7'd0;
                    last_dev_next    = 1'b0;
                    result.status    = STATUS_FAIL;
                end
                else
                begin
                    active_next   = 1'b1;
                    result.status = STATUS_BEGUN;
                end
            end
            FUNC_BIT_PAIR:
            begin
                if (!active_reg)
                begin
                    result.status = STATUS_FAIL;
                end
                else if (item.id_bit && item.complement_bit)
                begin
                    last_disc_next   = 7'd0;
                    family_disc_next = 7'd0;
                    last_dev_next    = 1'b0;
                    active_next      = 1'b0;
                    result.status    = STATUS_FAIL;
                end
                else
                begin
                    // pick the direction, remember zeros taken at a discrepancy
                    if (item.id_bit != item.complement_bit)
                    begin
                        dir = item.id_bit;
                    end
                    else
                    begin
                        if (bit_pos_reg < last_disc_reg)
                        begin
                            dir = rom_bits_reg[idx];
                        end
                        else
                        begin
                            dir = (bit_pos_reg == last_disc_reg);
                        end
                        if (!dir)
                        begin
                            last_zero_next = bit_pos_reg;
                            if (bit_pos_reg < FAMILY_LIMIT)
                            begin
                                family_disc_next = bit_pos_reg;
                            end
                        end
                    end
                    rom_bits_next[idx] = dir;
                    result.write_valid = 1'b1;
                    result.direction   = dir;
                    result.status      = STATUS_CONTINUE;
                    bit_pos_next       = bit_pos_inc;

                    // fold in a completed byte
                    if (idx[2:0] == 3'd7)
                    begin
                        crc_byte = rom_bits_next[{idx[5:3], 3'b000} +: 8];
                        crc_next = crc8_lookup(crc_reg ^ crc_byte);
                    end

                    // end of the rom number
                    if (idx == ROM_BITS_TOTAL[5:0] - 6'd1)
                    begin
                        active_next = 1'b0;
                        if (bit_pos_inc >= BIT_END && crc_next == 8'd0)
                        begin
                            last_disc_next = last_zero_next;
                            if (last_zero_next == 7'd0)
                            begin
                                last_dev_next = 1'b1;
                            end
                            ok = 1'b1;
                        end
                        if (!ok || rom_bits_next[7:0] == 8'd0)
                        begin
                            last_disc_next   = 7'd0;
                            family_disc_next = 7'd0;
                            last_dev_next    = 1'b0;
                            result.status    = STATUS_FAIL;
                        end
                        else
                        begin
                            result.status      = STATUS_FOUND;
                            result.last_device = last_dev_next;
                        end
                    end
                end
            end
            FUNC_TARGET:
            begin
                rom_bits_next    = {56'd0, item.target_family};
                last_disc_next   = ROM_BITS_TOTAL;
                family_disc_next = 7'd0;
                last_dev_next    = 1'b0;
                active_next      = 1'b0;
            end
            FUNC_FAMILY_SKIP:
            begin
                last_disc_next   = family_disc_reg;
                family_disc_next = 7'd0;
                if (family_disc_reg == 7'd0)
                begin
                    last_dev_next = 1'b1;
                end
                active_next = 1'b0;
            end
            default:
            begin
                result.status = STATUS_ACK;
            end
        endcase

        result.rom_code = rom_bits_next;
    end

    // search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bits_reg    <= 64'd0;
            last_disc_reg   <= 7'd0;
            family_disc_reg <= 7'd0;
            last_dev_reg    <= 1'b0;
            bit_pos_reg     <= 7'd1;
            last_zero_reg   <= 7'd0;
            crc_reg         <= 8'd0;
            active_reg      <= 1'b0;
        end
        else if (advance)
        begin
            rom_bits_reg    <= rom_bits_next;
            last_disc_reg   <= last_disc_next;
            family_disc_reg <= family_disc_next;
            last_dev_reg    <= last_dev_next;
            bit_pos_reg     <= bit_pos_next;
            last_zero_reg   <= last_zero_next;
            crc_reg         <= crc_next;
            active_reg      <= active_next;
        end
    end

endmodule

// ----- sv/ors_out_stage.sv -----
// ----------------------------------------------------------------------------
// ors_out_stage
// Result register; holds a finished beat while the receiver stalls.
// ----------------------------------------------------------------------------
module ors_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 stage_valid,
    input  ors_pkg::ors_result_t stage_result,
    output logic                 advance,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ors_pkg::ors_result_t out_result
);
    import ors_pkg::*;

    logic        vld_reg;
    logic        vld_next;
    ors_result_t res_reg;

    // move on when the result register is free or being emptied
    assign advance    = stage_valid && (!vld_reg || !out_stall);
    assign out_valid  = vld_reg;
    assign out_result = res_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (advance)
        begin
            vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            vld_next = 1'b0;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= stage_result;
        end
    end

endmodule

// ----- sv/onewire_rom_search.sv -----
// ----------------------------------------------------------------------------
// onewire_rom_search
// Decision core of the 1-Wire ROM search: start, bit pair, target and skip.
// ----------------------------------------------------------------------------
// One input beat is taken every clock cycle unless an output stall holds it;
// each beat yields exactly one result beat, held in the input register, then
// in the result register. The rate is set by the combinational decision step
// that reads and updates the search state registers; the byte-wise CRC8 and
// the direction choice both fit in that one step. Stall on the output reaches
// the input in the same cycle once both registers are occupied.
module onewire_rom_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic        presence,
    input  logic        id_bit,
    input  logic        complement_bit,
    input  logic [7:0]  target_family,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        write_valid,
    output logic        direction,
    output logic [63:0] rom_code,
    output logic        last_device
);
    import ors_pkg::*;

    ors_item_t   in_item;
    ors_item_t   stage_item;
    ors_result_t stage_result;
    ors_result_t out_result;
    logic        stage_valid;
    logic        advance;

    // pack the input beat
    assign in_item.func           = func;
    assign in_item.presence       = presence;
    assign in_item.id_bit         = id_bit;
    assign in_item.complement_bit = complement_bit;
    assign in_item.target_family  = target_family;

    ors_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    ors_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_item),
        .result  (stage_result)
    );

    ors_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid),
        .stage_result (stage_result),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_result   (out_result)
    );

    // unpack the result beat
    assign status      = out_result.status;
    assign write_valid = out_result.write_valid;
    assign direction   = out_result.direction;
    assign rom_code    = out_result.rom_code;
    assign last_device = out_result.last_device;

endmodule

// ----- sv/ors_checker.sv -----
// ----------------------------------------------------------------------------
// ors_checker
// Port-level checks of the ROM search core, bound to the top level.
// ----------------------------------------------------------------------------
module ors_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic        write_valid,
    input logic        direction,
    input logic [63:0] rom_code,
    input logic        last_device
);
    import ors_pkg::*;

    // no direction without a write
    a_dir_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_valid) |-> !direction)
        else $error("direction set without write_valid");

    // last device only reported with a found device
    a_last_dev_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_device) |-> (status == STATUS_FOUND))
        else $error("last_device outside device found");

    // a write only comes with a bit pair outcome
    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_valid) |->
        (status == STATUS_CONTINUE || status == STATUS_FOUND || status == STATUS_FAIL))
        else $error("write_valid with a non bit pair status");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(rom_code) && $stable(status)))
        else $error("stalled result beat changed");

endmodule

bind onewire_rom_search ors_checker u_ors_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .write_valid (write_valid),
    .direction   (direction),
    .rom_code    (rom_code),
    .last_device (last_device)
);
